[hdl/rjsc_pkg.sv]
// rjsc_pkg: shared types and constants of the remote jog servo controller
// used by rjsc_pulse_unit, remote_jog_servo_controller and its testbench; no dependencies
`default_nettype none

package rjsc_pkg;

	// angle limit of an ordinary joint and span of the pulse formula
	localparam logic [7:0] ANGLE_MAX = 8'd180;

	// division by 180 as multiply by ceil(2^28 / 180) and shift, exact below 2^20
	localparam int          DIV_SHIFT = 28;
	localparam logic [20:0] DIV_RECIP = 21'd1491309;

	// configuration register indexes
	localparam logic [1:0] REG_PULSE_MIN = 2'd0;
	localparam logic [1:0] REG_PULSE_MAX = 2'd1;
	localparam logic [1:0] REG_GRIPPER   = 2'd2;

	// pulse range registers handed to the pulse unit
	typedef struct packed {
		logic [11:0] pulse_min;
		logic [11:0] pulse_max;
	} pulse_cfg_t;

	// one angle update that needs a new pulse
	typedef struct packed {
		logic [1:0] channel;
		logic [7:0] angle;
	} servo_upd_t;

endpackage

`default_nettype wire

[hdl/rjsc_pulse_unit.sv]
// rjsc_pulse_unit: angle to pulse conversion, three register stages
// pulse = angle * (pulse_max - pulse_min) / 180 + pulse_min; depends on rjsc_pkg
`default_nettype none

module rjsc_pulse_unit (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       upd_valid,
	output logic                      upd_ready,
	input  wire rjsc_pkg::servo_upd_t upd,
	input  wire rjsc_pkg::pulse_cfg_t cfg,
	output logic                      out_valid,
	input  wire                       out_ready,
	output logic [1:0]                channel,
	output logic [11:0]               pulse
);

	logic               v_s1, v_s2, v_s3;
	logic               en1, en2, en3;
	logic signed [21:0] prod_s1;
	logic               big_s1, big_s2;
	logic [1:0]         chan_s1, chan_s2;
	logic [40:0]        recip_s2;
	logic               neg_s2;
	logic signed [12:0] span;
	logic signed [21:0] prod_c;
	logic [21:0]        mag_c;
	logic [12:0]        quot_c;
	logic signed [13:0] val_c;

	// stall chain, a stage moves when the next one is free or moving
	assign en3       = !v_s3 || out_ready;
	assign en2       = !v_s2 || en3;
	assign en1       = !v_s1 || en2;
	assign upd_ready = en1;

	// stage 1: angle times signed span
	assign span   = $signed({1'b0, cfg.pulse_max}) - $signed({1'b0, cfg.pulse_min});
	assign prod_c = $signed({1'b0, upd.angle}) * span;

	// stage 2: magnitude times reciprocal of 180
	assign mag_c = prod_s1[21] ? 22'(-prod_s1) : 22'(prod_s1);

	// stage 3: shift, restore sign, add offset
	assign quot_c = recip_s2[40:rjsc_pkg::DIV_SHIFT];
	assign val_c  = (neg_s2 ? -$signed({1'b0, quot_c}) : $signed({1'b0, quot_c}))
		+ $signed({2'b00, cfg.pulse_min});

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) v_s1 <= upd_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (en1) begin
			prod_s1 <= prod_c;
			big_s1  <= upd.angle > rjsc_pkg::ANGLE_MAX;
			chan_s1 <= upd.channel;
		end
		if (en2) begin
			recip_s2 <= 41'(mag_c[19:0] * rjsc_pkg::DIV_RECIP);
			neg_s2   <= prod_s1[21];
			big_s2   <= big_s1;
			chan_s2  <= chan_s1;
		end
		if (en3) begin
			channel <= chan_s2;
			pulse   <= big_s2 ? 12'd0 : val_c[11:0];
		end
	end

	assign out_valid = v_s3;

endmodule

`default_nettype wire

[hdl/remote_jog_servo_controller.sv]
// remote_jog_servo_controller: servo selection, jog mode and angle state
// depends on rjsc_pkg and rjsc_pulse_unit
`default_nettype none

// channel  signals                              direction
// in       in_valid, in_ready, command, ir_code  transfer in
// out      out_valid, out_ready, channel, pulse  transfer out
// cfg      cfg_we, cfg_index, cfg_data          write only, no wait
//
// one item accepted per cycle while in_ready is high; a result leaves through five
// register stages
// (input register, state update, multiply, reciprocal multiply, output register)
// reset restores angles 90, 30, 180, 0, servo 0 selected, mode stop
// each stage holds only while its successor is full and stalled, so input keeps
// flowing into empty stages while a result waits at the output

module remote_jog_servo_controller #(
	parameter int NUM_SERVOS = 4
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_ready,
	input  wire         command,
	input  wire  [15:0] ir_code,
	output logic        out_valid,
	input  wire         out_ready,
	output logic [1:0]  channel,
	output logic [11:0] pulse,
	input  wire         cfg_we,
	input  wire  [1:0]  cfg_index,
	input  wire  [11:0] cfg_data
);

	localparam int SEL_W = $clog2(NUM_SERVOS);

	// jog modes
	localparam logic [1:0] MODE_STOP = 2'd0;
	localparam logic [1:0] MODE_UP   = 2'd1;
	localparam logic [1:0] MODE_DOWN = 2'd2;

	// remote codes: selection prefixes and mode codes in the low eleven bits
	localparam logic [12:0] SEL_PREFIX_A = 13'h0200;
	localparam logic [12:0] SEL_PREFIX_B = 13'h0300;
	localparam logic [10:0] KEY_UP       = 11'h010;
	localparam logic [10:0] KEY_DOWN     = 11'h011;
	localparam logic [10:0] KEY_STOP     = 11'h017;

	function automatic logic [7:0] start_angle(input int idx);
		logic [7:0] a;
		case (idx)
			0:       a = 8'd90;
			1:       a = 8'd30;
			2:       a = 8'd180;
			default: a = 8'd0;
		endcase
		return a;
	endfunction

	logic [11:0]          pulse_min_q, pulse_max_q;
	logic [7:0]           gripper_q;
	logic [SEL_W-1:0]     sel_q;
	logic [1:0]           mode_q;
	logic [7:0]           angle_q [NUM_SERVOS];

	logic                 in_v_s1;
	logic                 cmd_s1;
	logic [15:0]          code_s1;
	logic                 upd_v_s2;
	rjsc_pkg::servo_upd_t upd_s2;

	logic                 en1, en2, unit_ready;
	logic                 is_sel, sel_ok;
	logic [1:0]           sel_idx;
	logic                 is_mode_bank;
	logic [7:0]           cur_angle, limit, new_angle;
	logic                 at_last, changed;
	rjsc_pkg::pulse_cfg_t pcfg;

	// stall chain
	assign en2      = !upd_v_s2 || unit_ready;
	assign en1      = !in_v_s1 || en2;
	assign in_ready = en1;

	// remote code decode
	assign sel_idx      = 2'(code_s1[2:0] - 3'd1);
	assign is_sel       = (code_s1[15:3] == SEL_PREFIX_A || code_s1[15:3] == SEL_PREFIX_B)
		&& code_s1[2:0] >= 3'd1 && code_s1[2:0] <= 3'd4;
	assign sel_ok       = int'(sel_idx) < NUM_SERVOS;
	assign is_mode_bank = code_s1[15:12] == 4'h0;

	// tick: one step within the limits of the selected servo
	assign cur_angle = angle_q[sel_q];
	assign at_last   = sel_q == SEL_W'(NUM_SERVOS - 1);
	assign limit     = at_last ? gripper_q : rjsc_pkg::ANGLE_MAX;
	always_comb begin
		new_angle = cur_angle;
		changed   = 1'b0;
		case (mode_q)
			MODE_UP: begin
				if (cur_angle < limit) begin
					new_angle = cur_angle + 8'd1;
					changed   = 1'b1;
				end
			end
			MODE_DOWN: begin
				if (cur_angle != 8'd0) begin
					new_angle = cur_angle - 8'd1;
					changed   = 1'b1;
				end
			end
			default: ;
		endcase
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pulse_min_q <= 12'd150;
			pulse_max_q <= 12'd550;
			gripper_q   <= 8'd60;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rjsc_pkg::REG_PULSE_MIN: pulse_min_q <= cfg_data;
				rjsc_pkg::REG_PULSE_MAX: pulse_max_q <= cfg_data;
				rjsc_pkg::REG_GRIPPER:   gripper_q   <= cfg_data[7:0];
				default:                 ;
			endcase
		end
	end

	// input register and state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_v_s1  <= 1'b0;
			upd_v_s2 <= 1'b0;
			sel_q    <= '0;
			mode_q   <= MODE_STOP;
			for (int i = 0; i < NUM_SERVOS; i++) angle_q[i] <= start_angle(i);
		end else begin
			if (en1) in_v_s1 <= in_valid;
			if (en2) upd_v_s2 <= in_v_s1 && cmd_s1 && changed;
			if (en2 && in_v_s1) begin
				if (cmd_s1) begin
					angle_q[sel_q] <= new_angle;
				end else if (is_sel) begin
					if (sel_ok) sel_q <= SEL_W'(sel_idx);
				end else if (is_mode_bank) begin
					if (code_s1[10:0] == KEY_UP)
						mode_q <= MODE_UP;
					else if (code_s1[10:0] == KEY_DOWN)
						mode_q <= MODE_DOWN;
					else if (code_s1[10:0] == KEY_STOP)
						mode_q <= MODE_STOP;
				end
			end
		end
	end

	// payload of the input and update stages
	always_ff @(posedge clk) begin
		if (en1) begin
			cmd_s1  <= command;
			code_s1 <= ir_code;
		end
		if (en2) begin
			upd_s2.channel <= 2'(sel_q);
			upd_s2.angle   <= new_angle;
		end
	end

	assign pcfg.pulse_min = pulse_min_q;
	assign pcfg.pulse_max = pulse_max_q;

	rjsc_pulse_unit u_pulse (
		.clk       (clk),
		.arst_n    (arst_n),
		.upd_valid (upd_v_s2),
		.upd_ready (unit_ready),
		.upd       (upd_s2),
		.cfg       (pcfg),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.channel   (channel),
		.pulse     (pulse)
	);

	// selection never points past the last servo
	a_sel_range: assert property (@(posedge clk) disable iff (!arst_n)
		int'(sel_q) < NUM_SERVOS)
		else $error("selected servo out of range");

	// a tick that moves the angle produces an update
	a_tick_update: assert property (@(posedge clk) disable iff (!arst_n)
		(in_v_s1 && en2 && cmd_s1 && changed) |=> upd_v_s2)
		else $error("angle change without update");

	// a remote code leaves the angle of the selected servo alone
	a_remote_no_move: assert property (@(posedge clk) disable iff (!arst_n)
		(in_v_s1 && en2 && !cmd_s1) |=> angle_q[$past(sel_q)] == $past(cur_angle))
		else $error("remote code changed an angle");

	// a held update stays put while the pulse unit is stalled
	a_upd_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(upd_v_s2 && !unit_ready) |=> upd_v_s2 && $stable(upd_s2))
		else $error("update lost under stall");

endmodule

`default_nettype wire

[dv/tb_remote_jog_servo_controller.sv]
// tb_remote_jog_servo_controller: self-checking bench for the remote jog servo controller
// drives remote codes and ticks, predicts channel and pulse per transfer and checks in order
// depends on rjsc_pkg and remote_jog_servo_controller
`timescale 1ns / 100ps

module tb_remote_jog_servo_controller;

	// command and remote code values
	localparam bit        CMD_REMOTE = 1'b0;
	localparam bit        CMD_TICK   = 1'b1;
	localparam bit [15:0] TOGGLE_BIT = 16'h0800;
	localparam bit [15:0] CODE_SEL0  = 16'h1001;
	localparam bit [15:0] CODE_SEL3  = 16'h1004;
	localparam bit [15:0] CODE_UP    = 16'h0010;
	localparam bit [15:0] CODE_DOWN  = 16'h0011;
	localparam bit [15:0] CODE_STOP  = 16'h0017;

	// index with no register behind it
	localparam bit [1:0] REG_UNUSED = 2'd3;

	localparam int NUM_SERVOS   = 4;
	localparam int FULL_SWEEP   = 180;
	localparam int DRAIN_CYCLES = 12;
	localparam int HOLD_CYCLES  = 150;

	typedef enum bit [1:0] {JOG_STOP, JOG_UP, JOG_DOWN} jog_mode_t;

	typedef struct packed {
		bit [1:0]  channel;
		bit [11:0] pulse;
	} servo_pulse_t;

	// jog state predictor and in-order result checker
	class servo_scoreboard;
		bit [11:0]    pulse_lo;
		bit [11:0]    pulse_hi;
		bit [7:0]     grip_lim;
		bit [1:0]     sel;
		jog_mode_t    mode;
		bit [7:0]     ang [NUM_SERVOS];
		servo_pulse_t expected_pulses [$];
		int           errors;

		function new();
			pulse_lo = 12'd150;
			pulse_hi = 12'd550;
			grip_lim = 8'd60;
			sel = 2'd0;
			mode = JOG_STOP;
			ang = '{8'd90, 8'd30, 8'd180, 8'd0};
			errors = 0;
		endfunction

		function void set_reg(bit [1:0] idx, bit [11:0] data);
			case (idx)
				rjsc_pkg::REG_PULSE_MIN: pulse_lo = data;
				rjsc_pkg::REG_PULSE_MAX: pulse_hi = data;
				rjsc_pkg::REG_GRIPPER:   grip_lim = data[7:0];
				default: ;
			endcase
		endfunction

		// signed formula, quotient truncated toward zero
		function bit [11:0] angle_to_count(bit [7:0] deg);
			int span;
			int val;
			if (deg > rjsc_pkg::ANGLE_MAX)
				return 12'd0;
			span = int'(pulse_hi) - int'(pulse_lo);
			val = (int'(deg) * span) / FULL_SWEEP + int'(pulse_lo);
			return val[11:0];
		endfunction

		// one accepted input transfer
		function void note_item(bit cmd, bit [15:0] code);
			bit [15:0] plain;
			bit [7:0]  limit;
			bit [7:0]  old;
			servo_pulse_t res;
			plain = code & ~TOGGLE_BIT;
			if (cmd == CMD_REMOTE) begin
				if (plain >= CODE_SEL0 && plain <= CODE_SEL3) begin
					sel = 2'(plain - CODE_SEL0);
				end else if (plain == CODE_UP) begin
					mode = JOG_UP;
				end else if (plain == CODE_DOWN) begin
					mode = JOG_DOWN;
				end else if (plain == CODE_STOP) begin
					mode = JOG_STOP;
				end
				return;
			end
			old = ang[sel];
			if (mode == JOG_UP) begin
				limit = (int'(sel) == NUM_SERVOS - 1) ? grip_lim : rjsc_pkg::ANGLE_MAX;
				if (ang[sel] < limit)
					ang[sel] = ang[sel] + 8'd1;
			end else if (mode == JOG_DOWN) begin
				if (ang[sel] > 8'd0)
					ang[sel] = ang[sel] - 8'd1;
			end
			if (ang[sel] != old) begin
				res.channel = sel;
				res.pulse = angle_to_count(ang[sel]);
				expected_pulses.push_back(res);
			end
		endfunction

		task report_mismatch(string what);
			$display("mismatch at %0t: %s", $realtime, what);
			errors++;
		endtask

		// one accepted result transfer
		task check_pulse(bit [1:0] ch, bit [11:0] pl);
			servo_pulse_t exp_res;
			if (expected_pulses.size() == 0) begin
				report_mismatch($sformatf("result ch %0d pulse %0d with none expected", ch, pl));
				return;
			end
			exp_res = expected_pulses.pop_front();
			if (ch != exp_res.channel)
				report_mismatch($sformatf("channel %0d, expected %0d", ch, exp_res.channel));
			if (pl != exp_res.pulse)
				report_mismatch($sformatf("pulse %0d, expected %0d", pl, exp_res.pulse));
		endtask

		function int pending();
			return expected_pulses.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic        command;
	logic [15:0] ir_code;
	logic        out_valid;
	logic        out_ready;
	logic [1:0]  channel;
	logic [11:0] pulse;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [11:0] cfg_data;

	servo_scoreboard sb;
	bit idle_in;
	bit idle_out;
	bit hold_req;
	int hold_left;

	remote_jog_servo_controller dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.command   (command),
		.ir_code   (ir_code),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.channel   (channel),
		.pulse     (pulse),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		#3_000_000;
		$display("TB_ERROR");
		$finish;
	end

	// receiver: random stalls plus a long counted hold-off on request
	initial begin
		out_ready = 1'b0;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_left = HOLD_CYCLES;
				hold_req = 1'b0;
			end
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else if (idle_out && $urandom_range(99) < 33) begin
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// transfer monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				sb.note_item(command, ir_code);
			if (out_valid && out_ready)
				sb.check_pulse(channel, pulse);
		end
	end

	function automatic int gap_len();
		if (idle_in && $urandom_range(99) < 33)
			return $urandom_range(1, 4);
		return 0;
	endfunction

	// offer one item and wait for its transfer
	task send_item(input bit cmd, input bit [15:0] code);
		int gap;
		gap = gap_len();
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		ir_code <= code;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	// sender pause until every result is back and the pipeline is empty
	task settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task write_reg(input bit [1:0] idx, input bit [11:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.set_reg(idx, data);
	endtask

	task write_all(input bit [11:0] lo, input bit [11:0] hi, input bit [7:0] grip);
		write_reg(rjsc_pkg::REG_PULSE_MIN, lo);
		write_reg(rjsc_pkg::REG_PULSE_MAX, hi);
		write_reg(rjsc_pkg::REG_GRIPPER, {4'd0, grip});
	endtask

	function automatic bit [15:0] rand_toggle();
		return $urandom_range(1) ? TOGGLE_BIT : 16'h0000;
	endfunction

	function automatic bit [15:0] pick_mode();
		int r;
		r = $urandom_range(4);
		if (r < 2)
			return CODE_UP | rand_toggle();
		if (r < 4)
			return CODE_DOWN | rand_toggle();
		return CODE_STOP | rand_toggle();
	endfunction

	// mostly an optional select, a mode, then a run of ticks; some noise codes and lone ticks
	task run_bursts(input int n);
		int sent;
		int kind;
		int k;
		sent = 0;
		while (sent < n) begin
			kind = $urandom_range(9);
			if (kind == 0) begin
				send_item(CMD_REMOTE, 16'($urandom));
				sent++;
			end else if (kind == 1) begin
				send_item(CMD_TICK, 16'($urandom));
				sent++;
			end else begin
				if ($urandom_range(1)) begin
					send_item(CMD_REMOTE, (CODE_SEL0 + 16'($urandom_range(3))) | rand_toggle());
					sent++;
				end
				send_item(CMD_REMOTE, pick_mode());
				sent++;
				k = $urandom_range(1, 30);
				repeat (k) begin
					send_item(CMD_TICK, 16'($urandom));
					sent++;
				end
			end
		end
	endtask

	task run_ticks(input int n);
		repeat (n) send_item(CMD_TICK, 16'($urandom));
	endtask

	// directed items: modes, selections, limits, ignored codes
	localparam bit [16:0] DIRECTED [25] = '{
		{CMD_TICK, 16'hFFFF},
		{CMD_REMOTE, CODE_UP},
		{CMD_TICK, 16'h0000},
		{CMD_REMOTE, (CODE_SEL0 + 16'd1) | TOGGLE_BIT},
		{CMD_TICK, 16'h5A5A},
		{CMD_REMOTE, CODE_SEL0 + 16'd2},
		{CMD_TICK, 16'hA5A5},
		{CMD_REMOTE, CODE_DOWN | TOGGLE_BIT},
		{CMD_TICK, 16'h0000},
		{CMD_REMOTE, CODE_SEL3 | TOGGLE_BIT},
		{CMD_TICK, 16'hFFFF},
		{CMD_REMOTE, CODE_UP | TOGGLE_BIT},
		{CMD_TICK, 16'h1234},
		{CMD_REMOTE, CODE_STOP},
		{CMD_TICK, 16'h0000},
		{CMD_REMOTE, 16'h1005},
		{CMD_REMOTE, 16'h1800},
		{CMD_REMOTE, 16'h2010},
		{CMD_REMOTE, 16'h0012},
		{CMD_REMOTE, 16'hFFFF},
		{CMD_REMOTE, 16'h0000},
		{CMD_REMOTE, CODE_DOWN},
		{CMD_TICK, 16'h8000},
		{CMD_REMOTE, CODE_STOP | TOGGLE_BIT},
		{CMD_TICK, 16'h7FFF}
	};

	// main sequence
	initial begin
		sb = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		command = 1'b0;
		ir_code = 16'h0000;
		cfg_we = 1'b0;
		cfg_index = 2'd0;
		cfg_data = 12'd0;
		idle_in = 1'b1;
		idle_out = 1'b1;
		hold_req = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset settings, directed cases
		foreach (DIRECTED[i])
			send_item(DIRECTED[i][16], DIRECTED[i][15:0]);
		settle();

		// full pulse range, gripper at the ordinary limit
		write_all(12'd0, 12'd4095, 8'd180);
		run_bursts(200);
		settle();

		// reversed range, gripper closed, long output hold-off
		write_all(12'd4095, 12'd0, 8'd0);
		hold_req = 1'b1;
		send_item(CMD_REMOTE, CODE_SEL0 + 16'd1);
		send_item(CMD_REMOTE, CODE_UP);
		run_ticks(20);
		send_item(CMD_REMOTE, CODE_DOWN);
		run_ticks(20);
		run_bursts(160);
		settle();

		// gripper driven past 180 up to 255, then back down
		write_all(12'($urandom_range(4095)), 12'($urandom_range(4095)), 8'd255);
		write_reg(REG_UNUSED, 12'($urandom));
		send_item(CMD_REMOTE, CODE_SEL3);
		send_item(CMD_REMOTE, CODE_UP | TOGGLE_BIT);
		run_ticks(260);
		send_item(CMD_REMOTE, CODE_DOWN);
		run_ticks(6);
		settle();

		// random settings, first a stretch with no idling
		write_all(12'($urandom_range(4095)), 12'($urandom_range(4095)), 8'($urandom_range(180)));
		idle_in = 1'b0;
		idle_out = 1'b0;
		run_bursts(150);
		idle_in = 1'b1;
		idle_out = 1'b1;
		run_bursts(150);
		settle();

		while (sb.pending() != 0) begin
			sb.report_mismatch("expected result never arrived");
			void'(sb.expected_pulses.pop_front());
		end
		if (sb.errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

[sim.f]
hdl/rjsc_pkg.sv
hdl/rjsc_pulse_unit.sv
hdl/remote_jog_servo_controller.sv
dv/tb_remote_jog_servo_controller.sv
